// ===== sv/v4alu_pkg.sv =====
package v4alu_pkg;

   localparam logic [3:0] OPC_ADD    = 4'd0;
   localparam logic [3:0] OPC_SUB    = 4'd1;
   localparam logic [3:0] OPC_MUL    = 4'd2;
   localparam logic [3:0] OPC_SCALE  = 4'd3;
   localparam logic [3:0] OPC_DOT    = 4'd4;
   localparam logic [3:0] OPC_CROSS  = 4'd5;
   localparam logic [3:0] OPC_LERP   = 4'd6;
   localparam logic [3:0] OPC_LENGTH = 4'd7;
   localparam logic [3:0] OPC_NORM   = 4'd8;

   localparam int ROOT_STEPS = 33;
   localparam int DIV_STEPS  = 17;
   localparam int LAST_STG   = ROOT_STEPS + DIV_STEPS;

   localparam logic signed [32:0] ONE_Q = 33'sd65536;
   localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   typedef enum logic [3:0] {
      KIND_ADD,
      KIND_SUB,
      KIND_MUL,
      KIND_SCALE,
      KIND_DOT,
      KIND_CROSS,
      KIND_LERP,
      KIND_LENGTH,
      KIND_NORM,
      KIND_NONE
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic [3:0][31:0] a;
      logic [3:0][31:0] b;
      logic [31:0]      s;
   } item_type;

   typedef struct packed {
      logic     push;
      item_type item;
   } push_type;

   typedef struct packed {
      kind_type         kind;
      logic [3:0][31:0] a;
      logic [3:0][31:0] b;
      logic [7:0][65:0] m;
   } prod_type;

   typedef struct packed {
      kind_type         kind;
      logic [3:0][51:0] v;
      logic [63:0]      sq01;
      logic [63:0]      sq23;
      logic [3:0][31:0] amag;
      logic [3:0]       aneg;
   } comb_type;

   typedef struct packed {
      kind_type         kind;
      logic [3:0][31:0] r;
      logic             sat;
      logic             zl;
      logic [65:0]      nsq;
      logic [32:0]      root;
      logic [36:0]      rem;
      logic [3:0][31:0] amag;
      logic [3:0]       aneg;
      logic [3:0][32:0] drem;
      logic [3:0][16:0] quo;
   } stg_type;

   typedef struct packed {
      logic [3:0][31:0] r;
      logic             zl;
      logic             sat;
   } out_type;

   function automatic logic [32:0] sat32(input logic signed [51:0] v);
      logic [32:0] res;
      if (v > 52'sd2147483647) begin
         res = {1'b1, SAT_MAX};
      end else if (v < -52'sd2147483648) begin
         res = {1'b1, SAT_MIN};
      end else begin
         res = {1'b0, v[31:0]};
      end
      return res;
   endfunction

endpackage

// ===== sv/v4alu_front.sv =====
module v4alu_front import v4alu_pkg::*; (
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_opcode,
   input  logic [31:0] req_a_x,
   input  logic [31:0] req_a_y,
   input  logic [31:0] req_a_z,
   input  logic [31:0] req_a_w,
   input  logic [31:0] req_b_x,
   input  logic [31:0] req_b_y,
   input  logic [31:0] req_b_z,
   input  logic [31:0] req_b_w,
   input  logic [31:0] req_scalar_in,
   input  logic        queue_full,
   output push_type    pq
);

   kind_type kind;

   always_comb begin
      case (req_opcode)
         OPC_ADD:    kind = KIND_ADD;
         OPC_SUB:    kind = KIND_SUB;
         OPC_MUL:    kind = KIND_MUL;
         OPC_SCALE:  kind = KIND_SCALE;
         OPC_DOT:    kind = KIND_DOT;
         OPC_CROSS:  kind = KIND_CROSS;
         OPC_LERP:   kind = KIND_LERP;
         OPC_LENGTH: kind = KIND_LENGTH;
         OPC_NORM:   kind = KIND_NORM;
         default:    kind = KIND_NONE;
      endcase
   end

   assign req_stall    = queue_full;
   assign pq.push      = req_valid && !queue_full;
   assign pq.item.kind = kind;
   assign pq.item.a    = {req_a_w, req_a_z, req_a_y, req_a_x};
   assign pq.item.b    = {req_b_w, req_b_z, req_b_y, req_b_x};
   assign pq.item.s    = req_scalar_in;

endmodule

// ===== sv/v4alu_queue.sv =====
module v4alu_queue import v4alu_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  push_type pq,
   input  logic     pop,
   output item_type head,
   output logic     head_valid,
   output logic     full
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   item_type          mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_pop;

   assign head       = mem_ff[rd_ptr_ff];
   assign head_valid = count_ff != '0;
   assign full       = count_ff == CW'(DEPTH);
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (pq.push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (pq.push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!pq.push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pq.push) begin
         mem_ff[wr_ptr_ff] <= pq.item;
      end
   end

endmodule

// ===== sv/v4alu_back.sv =====
module v4alu_back import v4alu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  item_type    head,
   input  logic        head_valid,
   output logic        pop,
   input  logic [16:0] eps,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output out_type     rsp
);

   logic                en;
   logic                p1v_ff, c2v_ff, out_valid_ff;
   logic [LAST_STG:0]   sv_ff;
   prod_type            p1_ff, p1_in;
   comb_type            c2_ff, c2_in;
   stg_type             st_ff [0:LAST_STG];
   stg_type             st_in [0:LAST_STG];
   out_type             out_ff, out_in;

   logic signed [32:0]  opl [8];
   logic signed [32:0]  opr [8];
   logic signed [32:0]  av [4];
   logic signed [32:0]  bv [4];
   logic signed [32:0]  sa, oms;
   logic signed [49:0]  f [8];
   logic signed [51:0]  ea [4];
   logic signed [51:0]  eb [4];
   logic signed [51:0]  lane [4];
   logic [32:0]         sr [4];

   assign en        = !out_valid_ff || !rsp_stall;
   assign pop       = en && head_valid;
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   // Multiplier operand selection and the eight products.
   always_comb begin
      sa  = 33'($signed(head.s));
      oms = ONE_Q - sa;
      for (int i = 0; i < 4; i++) begin
         av[i]    = 33'($signed(head.a[i]));
         bv[i]    = 33'($signed(head.b[i]));
         opl[i]   = av[i];
         opr[i]   = bv[i];
         opl[i+4] = bv[i];
         opr[i+4] = sa;
      end
      case (head.kind)
         KIND_SCALE: begin
            for (int i = 0; i < 4; i++) opr[i] = sa;
         end
         KIND_LERP: begin
            for (int i = 0; i < 4; i++) opr[i] = oms;
         end
         KIND_LENGTH, KIND_NORM: begin
            for (int i = 0; i < 4; i++) opr[i] = av[i];
         end
         KIND_CROSS: begin
            opl[0] = av[1]; opr[0] = bv[2]; opl[4] = av[2]; opr[4] = bv[1];
            opl[1] = av[2]; opr[1] = bv[0]; opl[5] = av[0]; opr[5] = bv[2];
            opl[2] = av[0]; opr[2] = bv[1]; opl[6] = av[1]; opr[6] = bv[0];
         end
         default: ;
      endcase
      p1_in.kind = head.kind;
      p1_in.a    = head.a;
      p1_in.b    = head.b;
      for (int k = 0; k < 8; k++) begin
         p1_in.m[k] = 66'(opl[k]) * 66'(opr[k]);
      end
   end

   // Lane sums and differences, or floored products combined per lane.
   always_comb begin
      for (int k = 0; k < 8; k++) f[k] = $signed(p1_ff.m[k][65:16]);
      c2_in.kind = p1_ff.kind;
      c2_in.v    = '0;
      for (int i = 0; i < 4; i++) begin
         ea[i]         = 52'($signed(p1_ff.a[i]));
         eb[i]         = 52'($signed(p1_ff.b[i]));
         c2_in.aneg[i] = p1_ff.a[i][31];
         c2_in.amag[i] = p1_ff.a[i][31] ? (~p1_ff.a[i] + 32'd1) : p1_ff.a[i];
      end
      case (p1_ff.kind)
         KIND_ADD: begin
            for (int i = 0; i < 4; i++) c2_in.v[i] = ea[i] + eb[i];
         end
         KIND_SUB: begin
            for (int i = 0; i < 4; i++) c2_in.v[i] = ea[i] - eb[i];
         end
         KIND_MUL, KIND_SCALE: begin
            for (int i = 0; i < 4; i++) c2_in.v[i] = 52'(f[i]);
         end
         KIND_DOT: begin
            c2_in.v[0] = 52'(f[0]) + 52'(f[1]);
            c2_in.v[1] = 52'(f[2]) + 52'(f[3]);
         end
         KIND_CROSS: begin
            for (int i = 0; i < 3; i++) c2_in.v[i] = 52'(f[i]) - 52'(f[i+4]);
         end
         KIND_LERP: begin
            for (int i = 0; i < 4; i++) c2_in.v[i] = 52'(f[i]) + 52'(f[i+4]);
         end
         default: ;
      endcase
      c2_in.sq01 = p1_ff.m[0][63:0] + p1_ff.m[1][63:0];
      c2_in.sq23 = p1_ff.m[2][63:0] + p1_ff.m[3][63:0];
   end

   // Dot reduction, saturation and the sum of squares.
   always_comb begin
      for (int i = 0; i < 4; i++) lane[i] = $signed(c2_ff.v[i]);
      if (c2_ff.kind == KIND_DOT) begin
         lane[0] = lane[0] + lane[1];
         lane[1] = '0;
      end
      st_in[0]      = '0;
      st_in[0].kind = c2_ff.kind;
      for (int i = 0; i < 4; i++) begin
         sr[i]         = sat32(lane[i]);
         st_in[0].r[i] = sr[i][31:0];
      end
      st_in[0].sat  = sr[0][32] | sr[1][32] | sr[2][32] | sr[3][32];
      st_in[0].nsq  = {1'b0, {1'b0, c2_ff.sq01} + {1'b0, c2_ff.sq23}};
      st_in[0].amag = c2_ff.amag;
      st_in[0].aneg = c2_ff.aneg;
   end

   // Square root, one result bit per stage.
   for (genvar k = 1; k <= ROOT_STEPS; k++) begin : g_root
      logic [36:0] trial, tsub;
      always_comb begin
         trial        = {st_ff[k-1].rem[34:0], st_ff[k-1].nsq[65:64]};
         tsub         = {2'b00, st_ff[k-1].root, 2'b01};
         st_in[k]     = st_ff[k-1];
         st_in[k].nsq = {st_ff[k-1].nsq[63:0], 2'b00};
         if (trial >= tsub) begin
            st_in[k].rem  = trial - tsub;
            st_in[k].root = {st_ff[k-1].root[31:0], 1'b1};
         end else begin
            st_in[k].rem  = trial;
            st_in[k].root = {st_ff[k-1].root[31:0], 1'b0};
         end
      end
   end

   // Restoring division of each magnitude times one by the length.
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      localparam int IDX = ROOT_STEPS + 1 + j;
      logic [32:0]      len;
      logic [3:0][32:0] src;
      logic [3:0]       dbit;
      logic [33:0]      dtr [4];
      logic [33:0]      dsub [4];
      always_comb begin
         len        = st_ff[IDX-1].root;
         st_in[IDX] = st_ff[IDX-1];
         if (j == 0) begin
            st_in[IDX].zl = (len == '0) || (len < {16'b0, eps});
            if (st_ff[IDX-1].kind == KIND_LENGTH) begin
               if (len[32] | len[31]) begin
                  st_in[IDX].r[0] = SAT_MAX;
                  st_in[IDX].sat  = 1'b1;
               end else begin
                  st_in[IDX].r[0] = len[31:0];
               end
            end
         end
         for (int i = 0; i < 4; i++) begin
            if (j == 0) begin
               src[i]  = {2'b00, st_ff[IDX-1].amag[i][31:1]};
               dbit[i] = st_ff[IDX-1].amag[i][0];
            end else begin
               src[i]  = st_ff[IDX-1].drem[i];
               dbit[i] = 1'b0;
            end
            dtr[i]  = {src[i], dbit[i]};
            dsub[i] = dtr[i] - {1'b0, len};
            if (dtr[i] >= {1'b0, len}) begin
               st_in[IDX].drem[i] = dsub[i][32:0];
               st_in[IDX].quo[i]  = {st_ff[IDX-1].quo[i][15:0], 1'b1};
            end else begin
               st_in[IDX].drem[i] = dtr[i][32:0];
               st_in[IDX].quo[i]  = {st_ff[IDX-1].quo[i][15:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      out_in.r   = st_ff[LAST_STG].r;
      out_in.sat = st_ff[LAST_STG].sat;
      out_in.zl  = 1'b0;
      if (st_ff[LAST_STG].kind == KIND_NORM) begin
         out_in.sat = 1'b0;
         if (st_ff[LAST_STG].zl) begin
            out_in.zl = 1'b1;
            out_in.r  = '0;
         end else begin
            for (int i = 0; i < 4; i++) begin
               out_in.r[i] = st_ff[LAST_STG].aneg[i]
                           ? (~{15'b0, st_ff[LAST_STG].quo[i]} + 32'd1)
                           : {15'b0, st_ff[LAST_STG].quo[i]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1v_ff       <= 1'b0;
         c2v_ff       <= 1'b0;
         sv_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         p1v_ff       <= pop;
         c2v_ff       <= p1v_ff;
         sv_ff        <= {sv_ff[LAST_STG-1:0], c2v_ff};
         out_valid_ff <= sv_ff[LAST_STG];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff  <= p1_in;
         c2_ff  <= c2_in;
         out_ff <= out_in;
         for (int k = 0; k <= LAST_STG; k++) st_ff[k] <= st_in[k];
      end
   end

endmodule

// ===== sv/vec4_alu_unit.sv =====
// Four-component signed Q16.16 vector unit: add, subtract, multiply, scale, dot, cross,
// lerp, length and normalize. A new beat can be accepted every cycle while req_stall is
// low. A result passes the product and combine registers, the 33-stage square root
// pipeline, the 17-stage divider and output register. A request queue of QUEUE_DEPTH
// beats sits between the decode front end and the arithmetic pipeline, so req_stall
// rises only when that queue is full. The pipeline holds while rsp_stall is high and
// a result waits. The length_epsilon register resets to 1 and is written through the
// csr channel, which is always ready; write it only while no beat is in flight.
module vec4_alu_unit import v4alu_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_opcode,
   input  logic [31:0] req_a_x,
   input  logic [31:0] req_a_y,
   input  logic [31:0] req_a_z,
   input  logic [31:0] req_a_w,
   input  logic [31:0] req_b_x,
   input  logic [31:0] req_b_y,
   input  logic [31:0] req_b_z,
   input  logic [31:0] req_b_w,
   input  logic [31:0] req_scalar_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_r_x,
   output logic [31:0] rsp_r_y,
   output logic [31:0] rsp_r_z,
   output logic [31:0] rsp_r_w,
   output logic        rsp_zero_length,
   output logic        rsp_saturated,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_length_epsilon
);

   logic [16:0] eps_ff;
   push_type    pq;
   item_type    head;
   logic        head_valid, full, pop;
   out_type     rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= 17'd1;
      end else if (csr_valid && csr_ready) begin
         eps_ff <= csr_length_epsilon;
      end
   end

   v4alu_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_a_x       (req_a_x),
      .req_a_y       (req_a_y),
      .req_a_z       (req_a_z),
      .req_a_w       (req_a_w),
      .req_b_x       (req_b_x),
      .req_b_y       (req_b_y),
      .req_b_z       (req_b_z),
      .req_b_w       (req_b_w),
      .req_scalar_in (req_scalar_in),
      .queue_full    (full),
      .pq            (pq)
   );

   v4alu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .pq         (pq),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (full)
   );

   v4alu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .eps        (eps_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   assign rsp_r_x         = rsp.r[0];
   assign rsp_r_y         = rsp.r[1];
   assign rsp_r_z         = rsp.r[2];
   assign rsp_r_w         = rsp.r[3];
   assign rsp_zero_length = rsp.zl;
   assign rsp_saturated   = rsp.sat;

endmodule

// ===== sv/v4alu_checker.sv =====
module v4alu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_r_x,
   input logic [31:0] rsp_r_y,
   input logic [31:0] rsp_r_z,
   input logic [31:0] rsp_r_w,
   input logic        rsp_zero_length,
   input logic        rsp_saturated
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("Result beat dropped while stalled.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_r_x) && $stable(rsp_r_y)
         && $stable(rsp_r_z) && $stable(rsp_r_w) && $stable(rsp_saturated))
      else $error("Result beat changed while stalled.");

   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_length |-> rsp_r_x == 32'd0 && rsp_r_y == 32'd0
         && rsp_r_z == 32'd0 && rsp_r_w == 32'd0 && !rsp_saturated)
      else $error("Zero-length result is not the clean zero vector.");

   a_sat_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_r_x == 32'h7FFF_FFFF || rsp_r_x == 32'h8000_0000 ||
         rsp_r_y == 32'h7FFF_FFFF || rsp_r_y == 32'h8000_0000 ||
         rsp_r_z == 32'h7FFF_FFFF || rsp_r_z == 32'h8000_0000 ||
         rsp_r_w == 32'h7FFF_FFFF || rsp_r_w == 32'h8000_0000)
      else $error("Saturated flag without a clamped component.");

endmodule

bind vec4_alu_unit v4alu_checker u_chk (.*);

// ===== dv/testbench.sv =====
module testbench;
   import v4alu_pkg::*;

   localparam logic [3:0] OPC_SPARE_LO = 4'd9;
   localparam logic [3:0] OPC_SPARE_HI = 4'd15;
   localparam int DRAIN_CYCLES = 80;
   localparam int RANDOM_BEATS = 1100;

   typedef struct packed {
      logic [3:0]       op;
      logic [3:0][31:0] a;
      logic [3:0][31:0] b;
      logic [31:0]      s;
   } vec_req_t;

   typedef struct packed {
      logic [3:0][31:0] r;
      logic             zl;
      logic             sat;
   } vec_res_t;

   class vec4_checker;
      vec_res_t    pending_results[$];
      logic [16:0] eps = 17'd1;
      int          matched = 0;
      int          mismatches = 0;
      int          zero_hits = 0;
      int          sat_hits = 0;
      int          op_count[16];

      function longint clamp32(longint v, inout bit flag);
         if (v > 64'sd2147483647) begin
            flag = 1;
            return 64'sd2147483647;
         end
         if (v < -64'sd2147483648) begin
            flag = 1;
            return -64'sd2147483648;
         end
         return v;
      endfunction

      function logic [65:0] floor_root(logic [65:0] n);
         logic [65:0] res;
         logic [65:0] bitv;
         res = 0;
         bitv = 66'd1 << 64;
         while (bitv > n) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (n >= res + bitv) begin
               n = n - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      function vec_res_t predict(vec_req_t q);
         longint av[4], bv[4], r[4];
         longint sv, oms;
         logic [65:0] sumsq, len;
         bit sat, zl;
         vec_res_t res;
         sat = 0;
         zl = 0;
         sv = longint'(signed'(q.s));
         sumsq = 0;
         for (int i = 0; i < 4; i++) begin
            av[i] = longint'(signed'(q.a[i]));
            bv[i] = longint'(signed'(q.b[i]));
            r[i] = 0;
            sumsq = sumsq + 66'(av[i] * av[i]);
         end
         len = floor_root(sumsq);
         case (q.op)
            OPC_ADD: for (int i = 0; i < 4; i++) r[i] = clamp32(av[i] + bv[i], sat);
            OPC_SUB: for (int i = 0; i < 4; i++) r[i] = clamp32(av[i] - bv[i], sat);
            OPC_MUL: for (int i = 0; i < 4; i++) r[i] = clamp32((av[i] * bv[i]) >>> 16, sat);
            OPC_SCALE: for (int i = 0; i < 4; i++) r[i] = clamp32((av[i] * sv) >>> 16, sat);
            OPC_DOT: begin
               oms = 0;
               for (int i = 0; i < 4; i++) oms += (av[i] * bv[i]) >>> 16;
               r[0] = clamp32(oms, sat);
            end
            OPC_CROSS: begin
               r[0] = clamp32(((av[1] * bv[2]) >>> 16) - ((av[2] * bv[1]) >>> 16), sat);
               r[1] = clamp32(((av[2] * bv[0]) >>> 16) - ((av[0] * bv[2]) >>> 16), sat);
               r[2] = clamp32(((av[0] * bv[1]) >>> 16) - ((av[1] * bv[0]) >>> 16), sat);
            end
            OPC_LERP: begin
               oms = 64'sd65536 - sv;
               for (int i = 0; i < 4; i++)
                  r[i] = clamp32(((av[i] * oms) >>> 16) + ((bv[i] * sv) >>> 16), sat);
            end
            OPC_LENGTH: begin
               if (len > 66'd2147483647) begin
                  sat = 1;
                  r[0] = 64'sd2147483647;
               end else begin
                  r[0] = longint'(len);
               end
            end
            OPC_NORM: begin
               if (len == 0 || len < 66'(eps)) begin
                  zl = 1;
               end else begin
                  for (int i = 0; i < 4; i++) r[i] = (av[i] * 64'sd65536) / longint'(len);
               end
            end
            default: ;
         endcase
         for (int i = 0; i < 4; i++) res.r[i] = r[i][31:0];
         res.zl = zl;
         res.sat = sat;
         return res;
      endfunction

      function void note_request(vec_req_t q);
         op_count[q.op]++;
         pending_results.push_back(predict(q));
      endfunction

      function void report(string what, vec_res_t want, vec_res_t got);
         mismatches++;
         if (mismatches <= 10)
            $display("MISMATCH %s: expected r=%h zl=%b sat=%b, got r=%h zl=%b sat=%b",
                     what, want.r, want.zl, want.sat, got.r, got.zl, got.sat);
      endfunction

      function void check_result(vec_res_t got);
         vec_res_t want;
         bit bad;
         if (pending_results.size() == 0) begin
            report("unexpected beat", '0, got);
            return;
         end
         want = pending_results.pop_front();
         bad = 0;
         for (int i = 0; i < 4; i++) if (got.r[i] !== want.r[i]) bad = 1;
         if (got.zl !== want.zl || got.sat !== want.sat) bad = 1;
         if (bad) report("result", want, got);
         else matched++;
         zero_hits += want.zl;
         sat_hits += want.sat;
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [3:0]  req_opcode = '0;
   logic [31:0] req_a_x = '0, req_a_y = '0, req_a_z = '0, req_a_w = '0;
   logic [31:0] req_b_x = '0, req_b_y = '0, req_b_z = '0, req_b_w = '0;
   logic [31:0] req_scalar_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [31:0] rsp_r_x, rsp_r_y, rsp_r_z, rsp_r_w;
   logic        rsp_zero_length, rsp_saturated;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [16:0] csr_length_epsilon = '0;

   vec4_checker book = new();
   int          stall_mode = 0;
   int          stall_count = 0;

   vec4_alu_unit dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            book.note_request({req_opcode, {req_a_w, req_a_z, req_a_y, req_a_x},
                               {req_b_w, req_b_z, req_b_y, req_b_x}, req_scalar_in});
         if (rsp_valid && !rsp_stall)
            book.check_result({{rsp_r_w, rsp_r_z, rsp_r_y, rsp_r_x},
                               rsp_zero_length, rsp_saturated});
         if (csr_valid && csr_ready) book.eps = csr_length_epsilon;
      end
   end

   always @(negedge clock) begin
      if (stall_count == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_count <= $urandom_range(20, 300);
      end else begin
         stall_count <= stall_count - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 0;
         1: rsp_stall <= ($urandom_range(0, 9) < 3);
         2: rsp_stall <= ($urandom_range(0, 9) < 8);
         default: rsp_stall <= (stall_count % 4 == 0);
      endcase
   end

   task automatic send_beat(vec_req_t q);
      @(negedge clock);
      req_valid = 1;
      req_opcode = q.op;
      {req_a_w, req_a_z, req_a_y, req_a_x} = q.a;
      {req_b_w, req_b_z, req_b_y, req_b_x} = q.b;
      req_scalar_in = q.s;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pause_sender(int n);
      @(negedge clock);
      req_valid = 0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain();
      pause_sender(0);
      while (book.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_epsilon(logic [16:0] value);
      @(negedge clock);
      csr_valid = 1;
      csr_length_epsilon = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 0;
   endtask

   function automatic logic [31:0] pick_field();
      case ($urandom_range(0, 11))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0;
         3: return 32'hFFFF_FFFF;
         4: return 32'h0001_0000;
         5, 6: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic vec_req_t pick_request(logic [16:0] eps);
      vec_req_t q;
      q.op = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(OPC_SPARE_LO, OPC_SPARE_HI))
                                        : 4'($urandom_range(OPC_ADD, OPC_NORM));
      for (int i = 0; i < 4; i++) begin
         q.a[i] = pick_field();
         q.b[i] = pick_field();
      end
      q.s = pick_field();
      if (q.op == OPC_NORM && $urandom_range(0, 2) == 0) begin
         q.a = '0;
         q.a[$urandom_range(0, 3)] = $urandom_range(0, 32'(eps) + 2);
      end
      return q;
   endfunction

   task automatic random_phase(int n, logic [16:0] eps);
      int burst;
      while (n > 0) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && n > 0; i++, n--) send_beat(pick_request(eps));
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(0, 12));
      end
   endtask

   task automatic directed_phase();
      vec_req_t q;
      for (int op = OPC_ADD; op <= OPC_NORM; op++) begin
         q.op = 4'(op);
         q.a = {4{32'h7FFF_FFFF}};
         q.b = {4{32'h8000_0000}};
         q.s = 32'h8000_0000;
         send_beat(q);
         q.a = {4{32'h8000_0000}};
         q.b = {4{32'h7FFF_FFFF}};
         q.s = 32'h7FFF_FFFF;
         send_beat(q);
      end
      q.op = OPC_NORM;
      q.a = '0;
      send_beat(q);
      q.a = {32'h0, 32'h0, 32'h0, 32'h0000_0001};
      send_beat(q);
      q.op = OPC_LERP;
      q.a = {32'h0003_0000, 32'hFFFE_0000, 32'h0001_8000, 32'h0000_0001};
      q.b = {32'hFFFF_0000, 32'h0002_0000, 32'h0000_4000, 32'h0005_0000};
      q.s = 32'h0;
      send_beat(q);
      q.s = 32'h0001_0000;
      send_beat(q);
      q.op = OPC_SPARE_HI;
      q.a = {4{32'hFFFF_FFFF}};
      send_beat(q);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;
      directed_phase();
      random_phase(300, 17'd1);
      drain();
      write_epsilon(17'd0);
      random_phase(200, 17'd0);
      drain();
      write_epsilon(17'd65536);
      random_phase(200, 17'd65536);
      drain();
      write_epsilon(17'($urandom_range(2, 65535)));
      random_phase(200, book.eps);
      drain();
      write_epsilon(17'd1);
      random_phase(RANDOM_BEATS - 900, 17'd1);
      drain();
      $display("Checked %0d results over nine opcodes and the spare codes, four epsilon values.",
               book.matched + book.mismatches);
      $display("Zero-length results: %0d, saturated results: %0d, mismatches: %0d.",
               book.zero_hits, book.sat_hits, book.mismatches);
      if (book.mismatches == 0 && book.pending_results.size() == 0) begin
         $display("vec4_alu_unit test passed");
      end else begin
         $display("vec4_alu_unit test failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("vec4_alu_unit test failed");
      $finish;
   end

endmodule
